// ===== hw/rtl/radix_number_parser_macros.svh =====
// Assertion macros shared by the radix number parser RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef RADIX_NUMBER_PARSER_MACROS_SVH
`define RADIX_NUMBER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RNP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rnp_pkg.sv =====
// Types and constants of the radix number parser.
// Used by rnp_char_decode, rnp_core and radix_number_parser; no dependencies.
package rnp_pkg;

  // Register indexes on the configuration port
  localparam logic REG_RADIX       = 1'b0;
  localparam logic REG_RESULT_BITS = 1'b1;

  // Register widths and reset values
  localparam int RADIX_W = 6;
  localparam int RBITS_W = 7;
  localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
  localparam logic [RBITS_W-1:0] RBITS_RST = 7'd64;

  // Legal register ranges
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RBITS_W-1:0] RBITS_MIN = 7'd8;

  // Bases that allow a prefix
  localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UP_B  = 8'h42;  // 'B'
  localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
  localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
  localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'

  // Digit value of a non-alphanumeric character, above any base
  localparam logic [6:0] NO_DIGIT = 7'd99;

  localparam int VALUE_W = 64;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  // Decoded character
  typedef struct packed {
    logic       is_dec;  // '0'..'9'
    logic [6:0] val;     // digit value, NO_DIGIT if none
  } digit_info_t;

  // One result item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

endpackage

// ===== hw/rtl/rnp_char_decode.sv =====
// Character to digit decoder of the radix number parser.
// Depends on rnp_pkg for the character constants and digit_info_t.
module rnp_char_decode (
  input  logic [7:0]          char_i,
  output rnp_pkg::digit_info_t info_o
);
  import rnp_pkg::*;

  logic is_dec;
  logic is_up;
  logic is_lo;

  assign is_dec = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_up  = (char_i >= CH_UP_A) && (char_i <= CH_UP_Z);
  assign is_lo  = (char_i >= CH_LO_A) && (char_i <= CH_LO_Z);

  // Decimal digits give 0..9; letters, upper or lower, give 10..35
  always_comb begin
    info_o.is_dec = is_dec;
    priority if (is_dec) begin
      info_o.val = 7'(char_i - CH_ZERO);
    end else if (is_up) begin
      info_o.val = 7'(char_i - CH_UP_A) + 7'd10;
    end else if (is_lo) begin
      info_o.val = 7'(char_i - CH_LO_A) + 7'd10;
    end else begin
      info_o.val = NO_DIGIT;
    end
  end

endmodule

// ===== hw/rtl/rnp_core.sv =====
// Numeral state and per-character update of the radix number parser.
// Depends on rnp_pkg, rnp_char_decode and radix_number_parser_macros.svh.
module rnp_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire_i,   // character consumed this cycle
  input  logic [7:0]                  char_i,
  input  logic                        last_i,
  input  logic [rnp_pkg::RADIX_W-1:0] radix_i,
  input  logic [rnp_pkg::RBITS_W-1:0] rbits_i,
  output rnp_pkg::result_t            result_o  // valid when fire_i && last_i
);
  import rnp_pkg::*;
  `include "radix_number_parser_macros.svh"

  localparam int PROD_W = MAX_WIDTH + RADIX_W + 1;

  // Numeral state
  logic [MAX_WIDTH-1:0] acc_r, acc_nxt;
  logic [1:0]           pos_r, pos_nxt;
  logic                 fwz_r, fwz_nxt;
  logic                 err_r, err_nxt;
  logic                 ovf_r, ovf_nxt;

  digit_info_t          dig;
  logic                 cfg_ok;
  logic                 pfx_slot;
  logic                 is_pfx;
  logic                 take;
  logic                 digit_ok;
  logic [MAX_WIDTH-1:0] lim;
  logic [PROD_W-1:0]    prod;
  logic                 prod_big;

  rnp_char_decode u_dec (
    .char_i (char_i),
    .info_o (dig)
  );

  // Register sanity
  assign cfg_ok = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX) &&
                  (rbits_i >= RBITS_MIN) && (rbits_i <= RBITS_W'(MAX_WIDTH));

  // Largest allowed value
  assign lim = (rbits_i >= RBITS_W'(MAX_WIDTH)) ? '1 : ~({MAX_WIDTH{1'b1}} << rbits_i);

  // Second character after a leading zero may be a prefix
  assign pfx_slot = (pos_r == 2'd1) && fwz_r && !last_i;
  assign is_pfx   = ((radix_i == RADIX_BIN) && (char_i == CH_LO_B || char_i == CH_UP_B)) ||
                    ((radix_i == RADIX_HEX) && (char_i == CH_LO_X || char_i == CH_UP_X));

  // Character goes through the digit path
  assign take     = !err_r && cfg_ok && (!pfx_slot || (!is_pfx && dig.is_dec));
  assign digit_ok = dig.val < 7'(radix_i);

  // acc*radix + digit, exact; overflow when it exceeds the limit
  assign prod     = PROD_W'(acc_r) * PROD_W'(radix_i) + PROD_W'(dig.val);
  assign prod_big = prod > PROD_W'(lim);

  // Next state for this character
  always_comb begin
    acc_nxt = acc_r;
    err_nxt = err_r;
    ovf_nxt = ovf_r;
    fwz_nxt = fwz_r;
    pos_nxt = (pos_r < 2'd2) ? pos_r + 2'd1 : pos_r;
    if (!err_r) begin
      if (!cfg_ok) begin
        err_nxt = 1'b1;
      end else if (pfx_slot && !is_pfx && !dig.is_dec) begin
        err_nxt = 1'b1;
      end else if (take) begin
        if (!digit_ok) begin
          err_nxt = 1'b1;
        end else if (!ovf_r) begin
          if (prod_big) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[MAX_WIDTH-1:0];
          end
        end
      end
      if (pos_r == 2'd0) begin
        fwz_nxt = (char_i == CH_ZERO) && !last_i &&
                  (radix_i == RADIX_BIN || radix_i == RADIX_HEX);
      end
    end
  end

  // Result on the last character; the limit in force now applies again
  always_comb begin
    if (err_nxt) begin
      result_o.value  = '1;
      result_o.status = STAT_INVALID;
    end else if (ovf_nxt || (acc_nxt > lim)) begin
      result_o.value  = '1;
      result_o.status = STAT_OVERFLOW;
    end else begin
      result_o.value  = VALUE_W'(acc_nxt);
      result_o.status = STAT_OK;
    end
  end

  // State registers; cleared after each numeral
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= 2'd0;
      fwz_r <= 1'b0;
      err_r <= 1'b0;
      ovf_r <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        acc_r <= '0;
        pos_r <= 2'd0;
        fwz_r <= 1'b0;
        err_r <= 1'b0;
        ovf_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        pos_r <= pos_nxt;
        fwz_r <= fwz_nxt;
        err_r <= err_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // Checks
  `RNP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, fire_i && last_i,
    pos_r == 2'd0 && !err_r && !ovf_r && acc_r == '0, "numeral state not cleared")
  `RNP_ASSERT_NEXT(a_ovf_freezes_acc, clk, rst_n, fire_i && ovf_r && !last_i,
    $stable(acc_r), "accumulator moved after overflow")
  `RNP_ASSERT_NEXT(a_err_sticky, clk, rst_n, fire_i && err_r && !last_i,
    err_r && $stable(acc_r), "error flag dropped inside a numeral")

endmodule

// ===== hw/rtl/radix_number_parser.sv =====
// Top level of the radix number parser: input register, config, result register.
// Depends on rnp_pkg, rnp_core and radix_number_parser_macros.svh.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------
//  in_     | slave     | tdata[7:0] character, tlast last character
//  out_    | master    | tdata[63:0] value, tuser[1:0] status
//  cfg_    | slave     | addr 0 radix, 1 result_bits; data[6:0]
//
// One character per cycle unless a last character is held by a stalled result;
// a result is presented once its last character has passed the input register
// and then the result register; the single multiply-add-compare on the
// accumulator sits between the two registers. Reset restores radix 10 and 64
// bits and clears the numeral. A stalled result holds only the last character
// of the next numeral; other characters keep flowing.
module radix_number_parser #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [1:0]  out_tuser,  // [1:0] status
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_data
);
  import rnp_pkg::*;
  `include "radix_number_parser_macros.svh"

  logic                 in_valid_r;
  logic [7:0]           in_char_r;
  logic                 in_last_r;
  logic [RADIX_W-1:0]   radix_r;
  logic [RBITS_W-1:0]   rbits_r;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r;
  result_t              res;
  logic                 proc_fire;

  // Character leaves the input register unless it is a last one blocked by the output
  assign proc_fire = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
      rbits_r <= RBITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_RADIX:       radix_r <= cfg_data[RADIX_W-1:0];
        REG_RESULT_BITS: rbits_r <= cfg_data;
        default:         rbits_r <= rbits_r;
      endcase
    end
  end

  rnp_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (proc_fire),
    .char_i   (in_char_r),
    .last_i   (in_last_r),
    .radix_i  (radix_r),
    .rbits_i  (rbits_r),
    .result_o (res)
  );

  // Result register
  always_comb begin
    priority if (proc_fire && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.status;

  // Checks
  `RNP_ASSERT_NEXT(a_last_held, clk, rst_n,
    in_valid_r && in_last_r && out_valid_r && !out_tready,
    in_valid_r && in_last_r && $stable(in_char_r), "blocked last character lost")
  `RNP_ASSERT_NOW(a_bad_is_ones, clk, rst_n, out_valid_r,
    out_res_r.status == STAT_OK || out_res_r.value == '1, "failed result not all ones")
  `RNP_ASSERT_NEXT(a_result_loaded, clk, rst_n, proc_fire && in_last_r,
    out_valid_r, "result register not loaded")

endmodule
